### rtl/pbsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsc_pkg
// Shared types, constants and character helpers of the PEM block sequence
// checker.
// ----------------------------------------------------------------------------
package pbsc_pkg;

   localparam int MAX_LENGTH_DEFAULT = 65536;

   localparam int DATA_W   = 8;
   localparam int COUNT_W  = 4;
   localparam int MAXB_W   = 17;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = MAXB_W;

   localparam int BEGIN_LEN = 26;
   localparam int END_LEN   = 24;
   localparam int BIDX_W    = 5;

   localparam logic [8*BEGIN_LEN-1:0] BEGIN_TEXT = "-----BEGIN PUBLIC KEY-----";
   localparam logic [8*END_LEN-1:0]   END_TEXT   = "-----END PUBLIC KEY-----";

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 4'd2;
   localparam logic [MAXB_W-1:0]  MAX_BYTES_RST   = 17'd65536;
   localparam logic [COUNT_W-1:0] BLOCKS_SAT      = 4'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;

   typedef enum logic [4:0] {
      PH_LEAD  = 5'b00001,
      PH_BEGIN = 5'b00010,
      PH_BODY  = 5'b00100,
      PH_AFTER = 5'b01000,
      PH_FAIL  = 5'b10000
   } phase_type;

   // per-byte control fanned out to every matcher cell
   typedef struct packed {
      logic step;
      logic flush;
   } cell_ctl_type;

   function automatic logic [DATA_W-1:0] end_char(input int idx);
      logic [DATA_W-1:0] ch;
      ch = END_TEXT[8*(END_LEN-1-idx) +: 8];
      return ch;
   endfunction

   function automatic logic [DATA_W-1:0] begin_char(input logic [BIDX_W-1:0] idx);
      logic [DATA_W-1:0] ch;
      ch = '0;
      for (int k = 0; k < BEGIN_LEN; k++) begin
         if (idx == BIDX_W'(k)) begin
            ch = BEGIN_TEXT[8*(BEGIN_LEN-1-k) +: 8];
         end
      end
      return ch;
   endfunction

   function automatic logic is_space(input logic [DATA_W-1:0] c);
      return c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
   endfunction

endpackage

### rtl/pbsc_match_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsc_match_cell
// One position of the END line matcher: holds whether the pattern prefix up
// to this position ends at the last byte, and hands that bit to its neighbor.
// ----------------------------------------------------------------------------
module pbsc_match_cell
   import pbsc_pkg::*;
#(
   parameter logic [DATA_W-1:0] PAT_CHAR = 8'h00
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] data_byte,
   input  logic              prev_hit,
   output logic              hit,
   output logic              hit_next
);

   logic hit_ff;
   logic hit_in;

   assign hit_next = prev_hit && (data_byte == PAT_CHAR);
   assign hit_in   = !ctl.flush && hit_next;
   assign hit      = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.step) begin
         hit_ff <= hit_in;
      end
   end

endmodule

### rtl/pbsc_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsc_out_queue
// Two-entry status queue between the checker core and the result channel.
// ----------------------------------------------------------------------------
module pbsc_out_queue
   import pbsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [STATUS_W-1:0] push_status,
   input  logic                pop,
   output logic                out_valid,
   output logic [STATUS_W-1:0] out_status,
   output logic                full
);

   logic [STATUS_W-1:0] entry_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          fill_ff, fill_in;
   logic                do_pop;

   assign out_valid  = (fill_ff != 2'd0);
   assign out_status = entry_ff[rd_ptr_ff];
   assign full       = (fill_ff == 2'd2);
   assign do_pop     = pop && out_valid;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_status;
      end
   end

endmodule

### rtl/pem_block_sequence_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_block_sequence_checker
// Checks a byte stream for an exact number of PUBLIC KEY PEM blocks.
// ----------------------------------------------------------------------------
// One bundle byte is taken per clock cycle, back to back, with no gaps
// between bundles. The END line is found by a row of 24 matcher cells, one
// per character, that each register one bit and pass it on with every byte
// taken, so a byte's cost does not depend on the text. A bundle's status is
// written, when its last byte is taken, into a two-entry queue that drives
// rsp; the queue lets the input keep flowing while a status waits, and the
// input stalls only when two statuses are waiting. Status: 0 accepted, 1 bad
// framing or block count, 2 bundle longer than min(max_bytes, MAX_LENGTH).
// ----------------------------------------------------------------------------
module pem_block_sequence_checker
   import pbsc_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // bundle bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last
   // status results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata    // [1:0] status, [7:2] zero
);

   localparam int CNT_W = $clog2(MAX_LENGTH + 2);
   localparam int LIM_W = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;

   logic [COUNT_W-1:0] block_count_ff;
   logic [MAXB_W-1:0]  max_bytes_ff;

   phase_type          phase_ff, phase_in, phase_nx;
   logic [BIDX_W-1:0]  bidx_ff, bidx_in, bidx_nx;
   logic [COUNT_W-1:0] blocks_ff, blocks_in, blocks_nx;
   logic [CNT_W-1:0]   count_ff, count_in, count_nx;

   logic                accept;
   logic                queue_full;
   logic                found;
   logic [DATA_W-1:0]   data_byte;
   logic [STATUS_W-1:0] status;
   logic [LIM_W-1:0]    limit;
   logic [STATUS_W-1:0] out_status;
   cell_ctl_type        cell_ctl;
   logic [END_LEN-1:0]  hit;
   logic [END_LEN-1:0]  hit_next;

   assign data_byte  = req_tdata[DATA_W-1:0];
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RST;
         max_bytes_ff   <= MAX_BYTES_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BLOCK_COUNT: block_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_MAX_BYTES:   max_bytes_ff   <= csr_wdata[MAXB_W-1:0];
            default:         ;
         endcase
      end
   end

   // END line matcher row
   assign found          = (phase_ff == PH_BODY) && hit_next[END_LEN-1];
   assign cell_ctl.step  = accept;
   assign cell_ctl.flush = (phase_ff != PH_BODY) || found || req_tlast;

   for (genvar i = 0; i < END_LEN; i++) begin : g_cell
      logic prev;
      if (i == 0) begin : g_head
         assign prev = 1'b1;
      end else begin : g_link
         assign prev = hit[i-1];
      end
      pbsc_match_cell #(
         .PAT_CHAR (end_char(i))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .data_byte (data_byte),
         .prev_hit  (prev),
         .hit       (hit[i]),
         .hit_next  (hit_next[i])
      );
   end

   // framing sequencer
   always_comb begin
      phase_nx  = phase_ff;
      bidx_nx   = bidx_ff;
      blocks_nx = blocks_ff;
      count_nx  = (count_ff <= CNT_W'(MAX_LENGTH)) ? count_ff + 1'b1 : count_ff;
      case (phase_ff)
         PH_LEAD: begin
            if (!is_space(data_byte)) begin
               if (blocks_ff >= block_count_ff || data_byte != begin_char('0)) begin
                  phase_nx = PH_FAIL;
               end else begin
                  phase_nx = PH_BEGIN;
                  bidx_nx  = BIDX_W'(1);
               end
            end
         end
         PH_BEGIN: begin
            if (data_byte == begin_char(bidx_ff)) begin
               bidx_nx = bidx_ff + 1'b1;
               if (bidx_ff == BIDX_W'(BEGIN_LEN - 1)) begin
                  phase_nx = PH_BODY;
               end
            end else begin
               phase_nx = PH_FAIL;
            end
         end
         PH_BODY: begin
            if (found) begin
               phase_nx = PH_AFTER;
               if (blocks_ff != BLOCKS_SAT) begin
                  blocks_nx = blocks_ff + 1'b1;
               end
            end
         end
         PH_AFTER: begin
            phase_nx = is_space(data_byte) ? PH_LEAD : PH_FAIL;
         end
         default: begin
            phase_nx = PH_FAIL;
         end
      endcase
   end

   always_comb begin
      limit = (LIM_W'(max_bytes_ff) > LIM_W'(MAX_LENGTH)) ? LIM_W'(MAX_LENGTH)
                                                         : LIM_W'(max_bytes_ff);
      if (LIM_W'(count_nx) > limit) begin
         status = STATUS_TOO_LONG;
      end else if ((phase_nx == PH_LEAD || phase_nx == PH_AFTER)
                   && blocks_nx == block_count_ff) begin
         status = STATUS_OK;
      end else begin
         status = STATUS_BAD;
      end
   end

   // clear the bundle state on the last byte
   always_comb begin
      phase_in  = phase_ff;
      bidx_in   = bidx_ff;
      blocks_in = blocks_ff;
      count_in  = count_ff;
      if (accept) begin
         if (req_tlast) begin
            phase_in  = PH_LEAD;
            bidx_in   = '0;
            blocks_in = '0;
            count_in  = '0;
         end else begin
            phase_in  = phase_nx;
            bidx_in   = bidx_nx;
            blocks_in = blocks_nx;
            count_in  = count_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LEAD;
         bidx_ff   <= '0;
         blocks_ff <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         bidx_ff   <= bidx_in;
         blocks_ff <= blocks_in;
         count_ff  <= count_in;
      end
   end

   pbsc_out_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (accept && req_tlast),
      .push_status (status),
      .pop         (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_status  (out_status),
      .full        (queue_full)
   );

   assign rsp_tdata = {{(8 - STATUS_W){1'b0}}, out_status};

endmodule

### rtl/pbsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsc_checker
// Port-level checks of the PEM block sequence checker, bound to the top.
// ----------------------------------------------------------------------------
module pbsc_checker
   import pbsc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a waiting status holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("status changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == STATUS_OK || rsp_tdata[1:0] == STATUS_BAD
                      || rsp_tdata[1:0] == STATUS_TOO_LONG) && rsp_tdata[7:2] == 6'd0)
      else $error("bad status code");

   // only a last byte makes a status appear
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready && req_tlast) |=> !rsp_tvalid)
      else $error("status without a last byte");

   a_last_gives_status: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("no status after last byte");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("status pending after reset");

endmodule

bind pem_block_sequence_checker pbsc_checker u_pbsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### test/bundle_status_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bundle_status_checker
// Watches the byte, status and register channels of the PEM block sequence
// checker, predicts the status of every bundle and compares it with the
// status that comes out.
// ----------------------------------------------------------------------------
module bundle_status_checker
   import pbsc_pkg::*;
#(
   parameter int MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   input  logic                  req_tlast,   // last
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [7:0]            rsp_tdata,   // [1:0] status, [7:2] zero
   output int                    outstanding,
   output int                    errors
);

   // predicted checker state and register copies
   phase_type            ph;
   logic [BIDX_W-1:0]    bidx;
   logic [BIDX_W-1:0]    eidx;
   logic [COUNT_W-1:0]   seen;
   int                   nbytes;
   logic [COUNT_W-1:0]   cfg_blocks;
   logic [MAXB_W-1:0]    cfg_maxb;

   logic [STATUS_W-1:0]  status_due[$];
   logic [STATUS_W-1:0]  want;
   logic [STATUS_W-1:0]  got_status;
   logic                 has_status;
   int                   err_count = 0;

   function automatic logic blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
   endfunction

   function automatic logic [7:0] begin_ch(input int k);
      return BEGIN_TEXT[8*(BEGIN_LEN-1-k) +: 8];
   endfunction

   function automatic logic [7:0] end_ch(input int k);
      return END_TEXT[8*(END_LEN-1-k) +: 8];
   endfunction

   // longest proper prefix of the END line that is also a suffix of its first k+1 chars
   function automatic int end_back(input int k);
      if (k < 5) begin
         return k;
      end else if (k < 19) begin
         return 0;
      end
      return k - 18;
   endfunction

   task automatic clear_bundle();
      ph = PH_LEAD;
      bidx = '0;
      eidx = '0;
      seen = '0;
      nbytes = 0;
   endtask

   task automatic scan_byte(input logic [7:0] c, input logic fin,
                            output logic done, output logic [STATUS_W-1:0] st);
      int j;
      int limit;
      if (nbytes <= MAX_LENGTH) nbytes++;
      case (ph)
         PH_LEAD: begin
            if (!blank(c)) begin
               if (seen >= cfg_blocks || c != begin_ch(0)) begin
                  ph = PH_FAIL;
               end else begin
                  ph = PH_BEGIN;
                  bidx = BIDX_W'(1);
               end
            end
         end
         PH_BEGIN: begin
            if (bidx < BEGIN_LEN && c == begin_ch(bidx)) begin
               bidx++;
               if (bidx == BEGIN_LEN) begin
                  ph = PH_BODY;
                  eidx = '0;
               end
            end else begin
               ph = PH_FAIL;
            end
         end
         PH_BODY: begin
            j = eidx;
            if (j >= END_LEN) j = 0;
            while (j > 0 && end_ch(j) != c) j = end_back(j - 1);
            if (end_ch(j) == c) j++;
            if (j == END_LEN) begin
               if (seen != BLOCKS_SAT) seen++;
               ph = PH_AFTER;
               j = 0;
            end
            eidx = BIDX_W'(j);
         end
         PH_AFTER: begin
            ph = blank(c) ? PH_LEAD : PH_FAIL;
         end
         default: begin
            ph = PH_FAIL;
         end
      endcase
      done = fin;
      st = STATUS_BAD;
      if (fin) begin
         limit = (cfg_maxb > MAX_LENGTH) ? MAX_LENGTH : int'(cfg_maxb);
         if (nbytes > limit) begin
            st = STATUS_TOO_LONG;
         end else if ((ph == PH_LEAD || ph == PH_AFTER) && seen == cfg_blocks) begin
            st = STATUS_OK;
         end
         clear_bundle();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_bundle();
         cfg_blocks = BLOCK_COUNT_RST;
         cfg_maxb = MAX_BYTES_RST;
         status_due.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata, req_tlast, has_status, got_status);
            if (has_status) status_due.insert(status_due.size(), got_status);
         end
         // a write lands after the byte taken on the same edge
         if (csr_we) begin
            if (csr_index == CSR_BLOCK_COUNT) begin
               cfg_blocks = csr_wdata[COUNT_W-1:0];
            end else if (csr_index == CSR_MAX_BYTES) begin
               cfg_maxb = csr_wdata[MAXB_W-1:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               $display("%0t ns: status transaction with none expected, actual %0d",
                        $time, rsp_tdata);
               err_count++;
            end else begin
               want = status_due.pop_front();
               if (rsp_tdata[STATUS_W-1:0] !== want) begin
                  $display("%0t ns: status mismatch, expected %0d, actual %0d",
                           $time, want, rsp_tdata[STATUS_W-1:0]);
                  err_count++;
               end
               if (rsp_tdata[7:STATUS_W] !== '0) begin
                  $display("%0t ns: status padding mismatch, expected 0, actual %0h",
                           $time, rsp_tdata[7:STATUS_W]);
                  err_count++;
               end
            end
         end
      end
      outstanding <= status_due.size();
      errors <= err_count;
   end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives text bundles, register settings and status back-pressure into the
// PEM block sequence checker; a checker module beside it predicts and
// compares every status.
// ----------------------------------------------------------------------------
module testbench;
   import pbsc_pkg::*;

   localparam int HOLD_CYCLES   = 300;
   localparam int TB_MAX_LENGTH = 1024;

   typedef enum int {
      B_CLEAN,
      B_FLIP,
      B_GLUE,
      B_CUT,
      B_LEAD,
      B_TAIL
   } bundle_flaw_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_THIRD,
      RX_MOSTLY
   } rx_pattern_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] data_byte
   logic                  req_tlast = 1'b0; // last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;        // [1:0] status, [7:2] zero
   int                    outstanding;
   int                    errors;

   logic [7:0] bundle[$];
   int         cur_blocks = BLOCK_COUNT_RST;
   int         burst_left = 0;
   logic       steady = 1'b0;
   logic       hold_ask = 1'b0;
   int         bundles_sent = 0;
   int         bytes_sent = 0;
   int         settings_used = 0;
   int         longest = 0;
   int         rand_bytes = 0;
   int         n;
   int         r;
   int         blocks;
   int         maxb;

   int             hold_left = 0;
   logic           hold_done = 1'b0;
   rx_pattern_type rx_mode = RX_OPEN;
   int             rx_tick = 0;
   int             rx_span = 200;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pem_block_sequence_checker #(.MAX_LENGTH(TB_MAX_LENGTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bundle_status_checker #(.MAX_LENGTH(TB_MAX_LENGTH)) status_chk (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .errors      (errors)
   );

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   task automatic put_byte(input logic [7:0] b);
      bundle.insert(bundle.size(), b);
   endtask

   task automatic add_blanks(input int count);
      for (int i = 0; i < count; i++) put_byte(pick_blank());
   endtask

   task automatic add_begin();
      for (int k = 0; k < BEGIN_LEN; k++) put_byte(BEGIN_TEXT[8*(BEGIN_LEN-1-k) +: 8]);
   endtask

   task automatic add_end_line(input int upto);
      for (int k = 0; k < upto; k++) put_byte(END_TEXT[8*(END_LEN-1-k) +: 8]);
   endtask

   // key text with noise, extreme bytes and near misses of the END line
   task automatic add_body();
      int len;
      len = $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: put_byte(8'($urandom_range(0, 255)));
            4, 5: put_byte(8'($urandom_range(8'h41, 8'h5a)));
            6: put_byte(CHAR_LF);
            7: add_end_line($urandom_range(1, END_LEN - 1));
            8: put_byte("-");
            default: put_byte($urandom_range(0, 1) ? 8'h00 : 8'hff);
         endcase
      end
   endtask

   task automatic build_bundle(input int nblk, input bundle_flaw_type flaw);
      int glue_at;
      int cut;
      bundle.delete();
      if (flaw == B_LEAD) put_byte(8'($urandom_range(8'h21, 8'h7e)));
      add_blanks($urandom_range(0, 3));
      glue_at = (flaw == B_GLUE && nblk > 0) ? $urandom_range(0, nblk - 1) : -1;
      for (int b = 0; b < nblk; b++) begin
         add_begin();
         add_body();
         add_end_line(END_LEN);
         if (b == glue_at) put_byte(8'($urandom_range(8'h21, 8'h7e)));
         if (b < nblk - 1) add_blanks($urandom_range(1, 3));
      end
      add_blanks($urandom_range(0, 3));
      if (flaw == B_TAIL) put_byte(8'($urandom_range(8'h21, 8'h7e)));
      if (flaw == B_FLIP && bundle.size() > 0) begin
         cut = $urandom_range(0, bundle.size() - 1);
         bundle[cut] = bundle[cut] ^ 8'($urandom_range(1, 255));
      end
      if (flaw == B_CUT && bundle.size() > 1) begin
         cut = $urandom_range(1, bundle.size() - 1);
         while (bundle.size() > cut) void'(bundle.pop_back());
      end
      if (bundle.size() == 0) put_byte(pick_blank());
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic fin);
      if (burst_left == 0) begin
         if (!steady) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   task automatic send_bundle();
      for (int i = 0; i < bundle.size(); i++) offer_byte(bundle[i], i == bundle.size() - 1);
      bundles_sent++;
      if (bundle.size() > longest) longest = bundle.size();
   endtask

   task automatic send_text(input logic [7:0] c0, input logic [7:0] c1, input int len);
      bundle.delete();
      put_byte(c0);
      if (len > 1) put_byte(c1);
      send_bundle();
   endtask

   // wait until every status is back, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int nblk, input int limit);
      logic [CSR_DATA_W-1:0] val;
      val = CSR_DATA_W'($urandom);     // upper bits are don't-care for the count
      val[COUNT_W-1:0] = COUNT_W'(nblk);
      write_reg(CSR_BLOCK_COUNT, val);
      write_reg(CSR_MAX_BYTES, CSR_DATA_W'(limit));
      cur_blocks = nblk;
      settings_used++;
   endtask

   // status receiver: changing stall patterns plus one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:  rsp_tready <= 1'b1;
               RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
               RX_THIRD: rsp_tready <= (rx_tick % 3 == 0);
               default:  rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
         rx_tick++;
         if (rx_tick >= rx_span) begin
            rx_tick = 0;
            rx_span = $urandom_range(64, 512);
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
         end
      end
   end

   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: two blocks, overlapping dashes, extreme body bytes
      bundle.delete();
      add_begin();
      put_byte(8'h00);
      put_byte(8'hff);
      put_byte("-");
      add_end_line(END_LEN);
      put_byte(CHAR_LF);
      add_begin();
      add_end_line(END_LEN - 1);
      put_byte("X");
      add_end_line(END_LEN);
      send_bundle();
      send_text(CHAR_LF, CHAR_LF, 1);
      send_text("-", "-", 1);
      settle();

      // zero length limit, then a whitespace bundle and a two-letter bundle with a one-byte limit
      apply_setting(1, 0);
      send_text(CHAR_SPACE, CHAR_SPACE, 1);
      settle();
      apply_setting(0, 1);
      send_text(CHAR_SPACE, CHAR_SPACE, 1);
      send_text("a", "b", 2);
      settle();

      // fifteen blocks padded to exactly the hard length limit
      apply_setting(15, (1 << MAXB_W) - 1);
      bundle.delete();
      add_blanks(2);
      for (int b = 0; b < 15; b++) begin
         add_begin();
         add_end_line(END_LEN);
         add_blanks(1);
      end
      while (bundle.size() < TB_MAX_LENGTH) put_byte(pick_blank());
      send_bundle();
      settle();

      while (rand_bytes < 250) begin
         r = $urandom_range(0, 9);
         blocks = (r == 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
         r = $urandom_range(0, 9);
         if (r < 5) maxb = MAX_BYTES_RST;
         else if (r == 5) maxb = $urandom_range(MAX_BYTES_RST, (1 << MAXB_W) - 1);
         else if (r < 9) maxb = $urandom_range(20, 60 * blocks + 80);
         else maxb = $urandom_range(0, 3);
         apply_setting(blocks, maxb);
         steady = ($urandom_range(0, 3) == 0);
         n = $urandom_range(2, 5);
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r < 11) build_bundle(cur_blocks, B_CLEAN);
            else if (r < 13) build_bundle((cur_blocks == 0) ? 1 :
                                          (r == 11 || cur_blocks == 15) ? cur_blocks - 1 :
                                          cur_blocks + 1, B_CLEAN);
            else if (r < 15) build_bundle(cur_blocks, B_FLIP);
            else if (r == 15) build_bundle(cur_blocks, B_GLUE);
            else if (r == 16 || r == 19) build_bundle(cur_blocks, B_CUT);
            else if (r == 17) build_bundle(cur_blocks, B_LEAD);
            else build_bundle(cur_blocks, B_TAIL);
            rand_bytes += bundle.size();
            send_bundle();
         end
         settle();
      end
      steady = 1'b0;

      // tiny bundles back to back while the receiver holds off
      apply_setting(0, MAX_BYTES_RST);
      steady = 1'b1;
      hold_ask <= 1'b1;
      for (int i = 0; i < 50; i++) begin
         bundle.delete();
         n = $urandom_range(1, 3);
         for (int k = 0; k < n; k++) begin
            put_byte($urandom_range(0, 1) ? pick_blank() : 8'($urandom_range(0, 255)));
         end
         send_bundle();
      end
      settle();
      steady = 1'b0;

      repeat (10) @(posedge clock);
      $display("Sent %0d bundles (%0d bytes) over %0d register settings, longest %0d bytes.",
               bundles_sent, bytes_sent, settings_used, longest);
      $display("Statuses were held off once for %0d cycles while short bundles kept coming.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
